[design/fdre_pkg.sv]
package fdre_pkg;

    localparam int IDX_W       = 24;
    localparam int TAG_W       = 16;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 6;

    typedef struct packed {
        logic              reliable_valid;
        logic [IDX_W-1:0]  reliable_index;
        logic              sequenced_valid;
        logic [IDX_W-1:0]  sequenced_index;
        logic              ordered_valid;
        logic [IDX_W-1:0]  ordered_index;
        logic [7:0]        order_channel;
        logic [TAG_W-1:0]  frame_tag;
    } in_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  delivered_tag;
        logic              last_of_run;
    } out_item_t;

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_REL     = 8'b0000_0100,
        S_REL_RUN = 8'b0000_1000,
        S_SEQ     = 8'b0001_0000,
        S_ORD     = 8'b0010_0000,
        S_STORE   = 8'b0100_0000,
        S_FLUSH   = 8'b1000_0000
    } state_t;

    // True when a is ahead of b by 1 .. 2^23-1 in wrapping index space.
    function automatic logic idx_ahead(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[IDX_W-1];
    endfunction

endpackage

[design/fdre_ram.sv]
module fdre_ram import fdre_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/frame_dedup_reorder_engine.sv]
// Frame duplicate filter and per-channel reorder buffer. Each accepted frame item runs
// a reliable-index duplicate check (expected index plus a sliding bitmap of early
// arrivals), a newest-sequenced check and, for ordered frames, in-order release
// through a reorder store of ORDER_CHANNELS rings of REORDER_DEPTH slots. Results
// leave as tag items with last_of_run set on the final one; dropped frames give none.
// The block handles one frame at a time. A frame that is not ordered passes the
// check sequencer states in order (accept, reliable, sequenced, ordered); an
// in-order reliable index adds a run state that absorbs early arrivals from the
// bitmap one per cycle, an early ordered frame adds a store state for the slot
// read-modify-write, and an in-order ordered frame adds a flush state that walks
// the slot memory one slot per cycle while the output register is free. After
// reset the block clears all ORDER_CHANNELS * REORDER_DEPTH slot entries and the
// channel memory and stalls frames until that pass ends. A finished item sits in
// an output register, so the next frame can be taken while it waits.
module frame_dedup_reorder_engine import fdre_pkg::*; #(
    parameter int ORDER_CHANNELS  = 32,
    parameter int REORDER_DEPTH   = 32,
    parameter int RELIABLE_WINDOW = 64,
    parameter int TAG_WIDTH       = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      frame_valid,
    output logic      frame_stall,
    input  in_item_t  frame,
    output logic      deliv_valid,
    input  logic      deliv_stall,
    output out_item_t deliv
);

    localparam int TW    = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;
    localparam int SLOTS = ORDER_CHANNELS * REORDER_DEPTH;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = (ORDER_CHANNELS > 1) ? $clog2(ORDER_CHANNELS) : 1;
    localparam int HW    = $clog2(REORDER_DEPTH);
    localparam int MW    = $clog2(RELIABLE_WINDOW);
    localparam int CDW   = IDX_W + HW;
    localparam int SDW   = TW + 1;

    state_t               state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic [IDX_W-1:0]     exp_rel_reg, exp_rel_next;
    logic [RELIABLE_WINDOW-1:0] map_reg, map_next;
    logic [IDX_W-1:0]     newest_reg, newest_next;
    logic [IDX_W-1:0]     exp_ord_reg, exp_ord_next;
    logic [HW-1:0]        head_reg, head_next;
    logic [TW-1:0]        pend_reg, pend_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SW-1:0]        slot_addr_reg, slot_addr_next;
    logic [SW-1:0]        clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic                 slot_we;
    logic [SW-1:0]        slot_waddr;
    logic [SDW-1:0]       slot_wdata, slot_rdata;
    logic                 chan_we;
    logic [CW-1:0]        chan_waddr;
    logic [CDW-1:0]       chan_wdata, chan_rdata;

    logic                 ch_ok;
    logic [CW-1:0]        ch_idx;
    logic [SW-1:0]        base;
    logic [IDX_W-1:0]     chan_exp;
    logic [HW-1:0]        chan_head;
    logic [IDX_W-1:0]     rel_dist, ord_dist;
    logic [HW:0]          pos_sum;
    logic [HW-1:0]        pos;
    logic [HW-1:0]        head_inc_rd, head_inc_reg;
    logic                 out_free;
    logic                 push;
    logic                 push_last;
    logic [TW-1:0]        push_tag;
    logic                 more;

    fdre_ram #(.DEPTH(SLOTS), .AW(SW), .DW(SDW)) u_slots (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_addr_next),
        .rdata (slot_rdata)
    );

    fdre_ram #(.DEPTH(ORDER_CHANNELS), .AW(CW), .DW(CDW)) u_chan (
        .clk   (clk),
        .we    (chan_we),
        .waddr (chan_waddr),
        .wdata (chan_wdata),
        .raddr (ch_idx),
        .rdata (chan_rdata)
    );

    // Channel bookkeeping. The channel table is read every cycle at the held item's
    // channel, so its word is ready by the time the ordered check runs.
    assign ch_ok     = {1'b0, item_reg.order_channel} < 9'(ORDER_CHANNELS);
    assign ch_idx    = ch_ok ? item_reg.order_channel[CW-1:0] : '0;
    assign base      = SW'(ch_idx * REORDER_DEPTH);
    assign chan_exp  = chan_rdata[CDW-1:HW];
    assign chan_head = chan_rdata[HW-1:0];

    assign rel_dist = item_reg.reliable_index - exp_rel_reg;
    assign ord_dist = item_reg.ordered_index - chan_exp;

    // The ring position of an early frame: head plus distance, both below the depth.
    assign pos_sum = {1'b0, chan_head} + {1'b0, ord_dist[HW-1:0]};
    assign pos     = (pos_sum >= (HW+1)'(REORDER_DEPTH)) ?
                     HW'(pos_sum - (HW+1)'(REORDER_DEPTH)) : pos_sum[HW-1:0];

    assign head_inc_rd  = (chan_head == HW'(REORDER_DEPTH - 1)) ? '0 : chan_head + 1'b1;
    assign head_inc_reg = (head_reg == HW'(REORDER_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign out_free = !out_valid_reg || !deliv_stall;
    assign more     = slot_rdata[TW] && (cnt_reg < CNT_W'(MAX_RESULTS));

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        exp_rel_next   = exp_rel_reg;
        map_next       = map_reg;
        newest_next    = newest_reg;
        exp_ord_next   = exp_ord_reg;
        head_next      = head_reg;
        pend_next      = pend_reg;
        cnt_next       = cnt_reg;
        slot_addr_next = slot_addr_reg;
        clr_next       = clr_reg;
        slot_we        = 1'b0;
        slot_waddr     = slot_addr_reg;
        slot_wdata     = '0;
        chan_we        = 1'b0;
        chan_waddr     = ch_idx;
        chan_wdata     = {exp_ord_reg, head_reg};
        push           = 1'b0;
        push_last      = 1'b0;
        push_tag       = pend_reg;

        case (state_reg)
            S_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                chan_we    = clr_reg < SW'(ORDER_CHANNELS);
                chan_waddr = clr_reg[CW-1:0];
                chan_wdata = '0;
                if (clr_reg == SW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (frame_valid)
                begin
                    item_next  = frame;
                    state_next = S_REL;
                end
            end

            S_REL:
            begin
                if (!item_reg.reliable_valid)
                begin
                    state_next = S_SEQ;
                end
                else if (idx_ahead(exp_rel_reg, item_reg.reliable_index))
                begin
                    state_next = S_IDLE;
                end
                else if (rel_dist == '0)
                begin
                    exp_rel_next = exp_rel_reg + 1'b1;
                    map_next     = map_reg >> 1;
                    state_next   = S_REL_RUN;
                end
                else if (rel_dist >= IDX_W'(RELIABLE_WINDOW))
                begin
                    state_next = S_IDLE;
                end
                else if (map_reg[rel_dist[MW-1:0]])
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    map_next[rel_dist[MW-1:0]] = 1'b1;
                    state_next = S_SEQ;
                end
            end

            S_REL_RUN:
            begin
                // Slide past early arrivals that are now contiguous, one per cycle.
                if (map_reg[0])
                begin
                    exp_rel_next = exp_rel_reg + 1'b1;
                    map_next     = map_reg >> 1;
                end
                else
                begin
                    state_next = S_SEQ;
                end
            end

            S_SEQ:
            begin
                if (item_reg.sequenced_valid &&
                    idx_ahead(newest_reg, item_reg.sequenced_index))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (item_reg.sequenced_valid)
                    begin
                        newest_next = item_reg.sequenced_index;
                    end
                    state_next = S_ORD;
                end
            end

            S_ORD:
            begin
                if (!item_reg.ordered_valid)
                begin
                    if (out_free)
                    begin
                        push       = 1'b1;
                        push_last  = 1'b1;
                        push_tag   = item_reg.frame_tag[TW-1:0];
                        state_next = S_IDLE;
                    end
                end
                else if (!ch_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (ord_dist == '0)
                begin
                    pend_next      = item_reg.frame_tag[TW-1:0];
                    cnt_next       = CNT_W'(1);
                    exp_ord_next   = chan_exp + 1'b1;
                    head_next      = head_inc_rd;
                    slot_addr_next = base + SW'(head_inc_rd);
                    state_next     = S_FLUSH;
                end
                else if (!ord_dist[IDX_W-1] && (ord_dist < IDX_W'(REORDER_DEPTH)))
                begin
                    slot_addr_next = base + SW'(pos);
                    state_next     = S_STORE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_STORE:
            begin
                // The first copy of an early frame is kept.
                if (!slot_rdata[TW])
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {1'b1, item_reg.frame_tag[TW-1:0]};
                end
                state_next = S_IDLE;
            end

            S_FLUSH:
            begin
                // The pending item is sent once the next slot shows whether it is last.
                if (out_free)
                begin
                    push = 1'b1;
                    if (more)
                    begin
                        slot_we        = 1'b1;
                        slot_wdata     = '0;
                        pend_next      = slot_rdata[TW-1:0];
                        cnt_next       = cnt_reg + 1'b1;
                        exp_ord_next   = exp_ord_reg + 1'b1;
                        head_next      = head_inc_reg;
                        slot_addr_next = base + SW'(head_inc_reg);
                    end
                    else
                    begin
                        push_last  = 1'b1;
                        chan_we    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && deliv_stall;
        if (push)
        begin
            out_valid_next         = 1'b1;
            out_next.delivered_tag = TAG_W'(push_tag);
            out_next.last_of_run   = push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            exp_rel_reg   <= '0;
            map_reg       <= '0;
            newest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            exp_rel_reg   <= exp_rel_next;
            map_reg       <= map_next;
            newest_reg    <= newest_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        exp_ord_reg   <= exp_ord_next;
        head_reg      <= head_next;
        pend_reg      <= pend_next;
        cnt_reg       <= cnt_next;
        slot_addr_reg <= slot_addr_next;
        out_reg       <= out_next;
    end

    assign frame_stall = (state_reg != S_IDLE);
    assign deliv_valid = out_valid_reg;
    assign deliv       = out_reg;

endmodule

[design/fdre_checker.sv]
module fdre_checker import fdre_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic frame_valid,
    input logic frame_stall,
    input logic deliv_valid,
    input logic deliv_stall
);

    // A result item that is stalled stays offered.
    a_deliv_hold: assert property (@(posedge clk) disable iff (!rst_n)
        deliv_valid && deliv_stall |=> deliv_valid)
        else $error("result item withdrawn while stalled");

    // Frames are worked one at a time, so an accept is followed by a busy cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_stall |=> frame_stall)
        else $error("frame accepted on consecutive cycles");

    // The memory clearing pass holds off frames when reset ends.
    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> frame_stall)
        else $error("frame port open before clearing pass");

endmodule

bind frame_dedup_reorder_engine fdre_checker u_fdre_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .deliv_valid (deliv_valid),
    .deliv_stall (deliv_stall)
);
